@@ rtl/gpm_pkg.sv @@
`default_nettype none

package gpm_pkg;

    localparam int COORD_BITS   = 24;
    localparam int T_FRAC_BITS  = 16;
    localparam int T_W          = T_FRAC_BITS + 1;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int MAG_W        = SQ_BITS + 1;
    localparam int DVD_W        = MAG_W + 2 * T_FRAC_BITS;
    localparam int DIV_STEPS    = DVD_W;
    localparam int RAD_W        = DVD_W + (DVD_W % 2);
    localparam int SQRT_STEPS   = RAD_W / 2;
    localparam int ROOT_W       = SQRT_STEPS;
    localparam int RS_W         = ROOT_W + 2;
    localparam int ANG_W        = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_SCALE = 28;
    localparam int CW           = DIFF_W + CORDIC_SCALE + 3;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_LAT     = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 2;
    localparam int ANG_DLY      = PIPE_LAT - CORDIC_STEPS - 4;
    localparam int CFG_IDX_W    = 3;

    localparam logic [T_W-1:0]   ONE_T     = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [ANG_W-1:0] HALF_TURN = {1'b1, {(ANG_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_END_X       = 3'd2,
        CFG_END_Y       = 3'd3,
        CFG_SHAPE_KIND  = 3'd4,
        CFG_SPREAD_MODE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_LINEAR  = 2'd0,
        KIND_RADIAL  = 2'd1,
        KIND_ANGULAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SPREAD_PAD     = 2'd0,
        SPREAD_REPEAT  = 2'd1,
        SPREAD_REFLECT = 2'd2
    } spread_t;

    typedef struct packed {
        logic                   q_neg;
        logic                   q_ge1;
        logic                   q_odd;
        logic                   inexact;
        logic [T_FRAC_BITS-1:0] frac;
    } tpos_t;

    typedef struct packed {
        logic neg;
        logic den_zero;
    } div_side_t;

    typedef struct packed {
        logic  den_zero;
        logic  div_inexact;
        tpos_t lin;
    } sq_side_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [DVD_W-1:0] dq;
    } div_st_t;

    typedef struct packed {
        logic [RS_W-1:0]   rs;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sq_st_t;

    typedef struct packed {
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [ANG_W-1:0] a;
    } cvec_t;

    function automatic logic [ANG_W-1:0] turn_step(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            5'd24:   r = 32'h00000028;
            5'd25:   r = 32'h00000014;
            5'd26:   r = 32'h0000000A;
            5'd27:   r = 32'h00000005;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gradient_parameter_mapper.sv @@
`default_nettype none

// stages from pixel transfer to ramp transfer: front, divider, quotient register, root, output register
// throughput: one pixel per clock; a stalled ramp output freezes the whole pipeline
// the divider (one quotient bit per stage) and root (one bit pair per stage)
// set the depth; the angle lane runs beside them
// reset empties the pipeline and clears every configuration register to zero

module gradient_parameter_mapper (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write_en,
    input  wire logic [gpm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [gpm_pkg::COORD_BITS-1:0]        cfg_data,
    input  wire logic                                  pixel_valid,
    output logic                                       pixel_stall,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] pixel_x,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] pixel_y,
    output logic                                       ramp_valid,
    input  wire logic                                  ramp_stall,
    output logic [gpm_pkg::T_W-1:0]                    ramp_position
);

    localparam int TW = gpm_pkg::T_W;
    localparam int TF = gpm_pkg::T_FRAC_BITS;
    localparam int NL = gpm_pkg::PIPE_LAT;
    localparam int VW = gpm_pkg::DVD_W;
    localparam int OW = gpm_pkg::ROOT_W;

    logic signed [gpm_pkg::COORD_BITS-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [1:0]                            shape_kind_reg, spread_mode_reg;
    logic [NL-1:0]                         vld_reg;
    logic [VW-1:0]                         pd_rad_reg;
    gpm_pkg::sq_side_t                     pd_side_reg;
    logic [TW-1:0]                         ramp_position_reg, ramp_position_next;

    logic                                  pipe_en;
    logic signed [gpm_pkg::DIFF_W-1:0]     vx, vy, dx, dy;
    logic [VW-1:0]                         dividend, quotient;
    logic [gpm_pkg::MAG_W-1:0]             den, remainder;
    gpm_pkg::div_side_t                    fr_side, dv_side;
    logic [OW-1:0]                         sq_root;
    logic                                  sq_rem_nz;
    gpm_pkg::sq_side_t                     sq_side, pd_side_next;
    logic [TF-1:0]                         ang_t;
    logic                                  lin_inx, lin_big;
    logic [TW-1:0]                         lin_low, lin_neg;
    gpm_pkg::tpos_t                        rad_tp;

    function automatic logic [TW-1:0] spread(input gpm_pkg::tpos_t tp,
                                             input logic [1:0] mode);
        logic [TW-1:0] f, r;
        f = TW'(tp.frac);
        case (mode)
            gpm_pkg::SPREAD_REPEAT:
            begin
                r = f;
            end
            gpm_pkg::SPREAD_REFLECT:
            begin
                if (!tp.q_odd)
                begin
                    r = f;
                end
                else if (tp.frac == '0 && !tp.inexact)
                begin
                    r = gpm_pkg::ONE_T;
                end
                else
                begin
                    r = gpm_pkg::ONE_T - f - TW'(tp.inexact);
                end
            end
            default:
            begin
                if (tp.q_neg)
                begin
                    r = '0;
                end
                else if (tp.q_ge1)
                begin
                    r = gpm_pkg::ONE_T;
                end
                else
                begin
                    r = f;
                end
            end
        endcase
        return r;
    endfunction

    assign pipe_en     = !(vld_reg[NL-1] && ramp_stall);
    assign pixel_stall = !pipe_en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            shape_kind_reg  <= '0;
            spread_mode_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                gpm_pkg::CFG_START_X:     start_x_reg     <= cfg_data;
                gpm_pkg::CFG_START_Y:     start_y_reg     <= cfg_data;
                gpm_pkg::CFG_END_X:       end_x_reg       <= cfg_data;
                gpm_pkg::CFG_END_Y:       end_y_reg       <= cfg_data;
                gpm_pkg::CFG_SHAPE_KIND:  shape_kind_reg  <= cfg_data[1:0];
                gpm_pkg::CFG_SPREAD_MODE: spread_mode_reg <= cfg_data[1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[NL-2:0], pixel_valid};
        end
    end

    gpm_front u_front (
        .clk      (clk),
        .en       (pipe_en),
        .kind     (shape_kind_reg),
        .start_x  (start_x_reg),
        .start_y  (start_y_reg),
        .end_x    (end_x_reg),
        .end_y    (end_y_reg),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .vx       (vx),
        .vy       (vy),
        .dx       (dx),
        .dy       (dy),
        .dividend (dividend),
        .den      (den),
        .side     (fr_side)
    );

    gpm_divider u_divider (
        .clk       (clk),
        .en        (pipe_en),
        .dividend  (dividend),
        .den       (den),
        .side_in   (fr_side),
        .quotient  (quotient),
        .remainder (remainder),
        .side_out  (dv_side)
    );

    // linear result: floor and fraction of the signed quotient
    always_comb
    begin
        lin_inx = |remainder;
        lin_big = |quotient[VW-1:TF];
        lin_low = quotient[TF:0] + TW'(lin_inx);
        lin_neg = -lin_low;
        pd_side_next.den_zero    = dv_side.den_zero;
        pd_side_next.div_inexact = lin_inx;
        pd_side_next.lin.inexact = lin_inx;
        if (dv_side.neg)
        begin
            pd_side_next.lin.q_neg = 1'b1;
            pd_side_next.lin.q_ge1 = 1'b0;
            pd_side_next.lin.q_odd = lin_neg[TF];
            pd_side_next.lin.frac  = lin_neg[TF-1:0];
        end
        else
        begin
            pd_side_next.lin.q_neg = 1'b0;
            pd_side_next.lin.q_ge1 = lin_big;
            pd_side_next.lin.q_odd = quotient[TF];
            pd_side_next.lin.frac  = quotient[TF-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pd_rad_reg  <= quotient;
            pd_side_reg <= pd_side_next;
        end
    end

    gpm_sqrt u_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .radicand (pd_rad_reg),
        .side_in  (pd_side_reg),
        .root     (sq_root),
        .rem_nz   (sq_rem_nz),
        .side_out (sq_side)
    );

    gpm_cordic u_cordic (
        .clk   (clk),
        .en    (pipe_en),
        .vx    (vx),
        .vy    (vy),
        .dx    (dx),
        .dy    (dy),
        .ang_t (ang_t)
    );

    always_comb
    begin
        rad_tp.q_neg   = 1'b0;
        rad_tp.q_ge1   = |sq_root[OW-1:TF];
        rad_tp.q_odd   = sq_root[TF];
        rad_tp.inexact = sq_rem_nz || sq_side.div_inexact;
        rad_tp.frac    = sq_root[TF-1:0];
        case (shape_kind_reg)
            gpm_pkg::KIND_LINEAR:  ramp_position_next = spread(sq_side.lin, spread_mode_reg);
            gpm_pkg::KIND_RADIAL:  ramp_position_next = spread(rad_tp, spread_mode_reg);
            gpm_pkg::KIND_ANGULAR: ramp_position_next = TW'(ang_t);
            default:               ramp_position_next = '0;
        endcase
        if (sq_side.den_zero)
        begin
            ramp_position_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ramp_position_reg <= ramp_position_next;
        end
    end

    assign ramp_valid    = vld_reg[NL-1];
    assign ramp_position = ramp_position_reg;

`ifndef NO_ASSERTIONS
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_valid && ramp_stall |-> pixel_stall)
        else $error("pipeline advanced while output stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_valid |-> ramp_position <= gpm_pkg::ONE_T)
        else $error("ramp position above one");

    a_angular: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_valid && shape_kind_reg == gpm_pkg::KIND_ANGULAR |-> !ramp_position[TF])
        else $error("angular position reached one");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_en && vld_reg[NL-2] |=> ramp_valid)
        else $error("item lost in last stage");
`endif

endmodule

`default_nettype wire

@@ rtl/gpm_front.sv @@
`default_nettype none

module gpm_front (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic [1:0]                            kind,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] start_x,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] start_y,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] end_x,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] end_y,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] pixel_x,
    input  wire logic signed [gpm_pkg::COORD_BITS-1:0] pixel_y,
    output logic signed [gpm_pkg::DIFF_W-1:0]          vx,
    output logic signed [gpm_pkg::DIFF_W-1:0]          vy,
    output logic signed [gpm_pkg::DIFF_W-1:0]          dx,
    output logic signed [gpm_pkg::DIFF_W-1:0]          dy,
    output logic [gpm_pkg::DVD_W-1:0]                  dividend,
    output logic [gpm_pkg::MAG_W-1:0]                  den,
    output gpm_pkg::div_side_t                         side
);

    localparam int DW = gpm_pkg::DIFF_W;
    localparam int PW = gpm_pkg::PROD_W;
    localparam int MW = gpm_pkg::MAG_W;
    localparam int SB = gpm_pkg::SQ_BITS;
    localparam int TF = gpm_pkg::T_FRAC_BITS;

    logic signed [DW-1:0] vx_reg, vy_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [gpm_pkg::DVD_W-1:0] dvd_reg;
    logic [MW-1:0]        den_reg;
    gpm_pkg::div_side_t   side_reg;

    logic                 radial;
    logic signed [DW-1:0] mul_b1, mul_b2;
    logic signed [PW:0]   num, num_abs;
    logic                 neg;
    logic [MW-1:0]        mag, den_sum;

    assign radial = (kind == gpm_pkg::KIND_RADIAL);
    assign mul_b1 = radial ? vx_reg : dx_reg;
    assign mul_b2 = radial ? vy_reg : dy_reg;

    always_comb
    begin
        num     = (PW + 1)'(pa_reg) + (PW + 1)'(pb_reg);
        neg     = num[PW];
        num_abs = neg ? -num : num;
        mag     = num_abs[MW-1:0];
        den_sum = {1'b0, pc_reg[SB-1:0]} + {1'b0, pd_reg[SB-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offsets from the start point
            vx_reg <= DW'(pixel_x) - DW'(start_x);
            vy_reg <= DW'(pixel_y) - DW'(start_y);
            dx_reg <= DW'(end_x) - DW'(start_x);
            dy_reg <= DW'(end_y) - DW'(start_y);
            // products
            pa_reg <= PW'(vx_reg) * PW'(mul_b1);
            pb_reg <= PW'(vy_reg) * PW'(mul_b2);
            pc_reg <= PW'(dx_reg) * PW'(dx_reg);
            pd_reg <= PW'(dy_reg) * PW'(dy_reg);
            // sums and dividend alignment
            den_reg           <= den_sum;
            side_reg.neg      <= neg;
            side_reg.den_zero <= (den_sum == '0);
            if (radial)
            begin
                dvd_reg <= {mag, {(2 * TF){1'b0}}};
            end
            else
            begin
                dvd_reg <= {{TF{1'b0}}, mag, {TF{1'b0}}};
            end
        end
    end

    assign vx       = vx_reg;
    assign vy       = vy_reg;
    assign dx       = dx_reg;
    assign dy       = dy_reg;
    assign dividend = dvd_reg;
    assign den      = den_reg;
    assign side     = side_reg;

endmodule

`default_nettype wire

@@ rtl/gpm_divider.sv @@
`default_nettype none

module gpm_divider (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [gpm_pkg::DVD_W-1:0]    dividend,
    input  wire logic [gpm_pkg::MAG_W-1:0]    den,
    input  wire gpm_pkg::div_side_t           side_in,
    output logic [gpm_pkg::DVD_W-1:0]         quotient,
    output logic [gpm_pkg::MAG_W-1:0]         remainder,
    output gpm_pkg::div_side_t                side_out
);

    localparam int MW = gpm_pkg::MAG_W;
    localparam int VW = gpm_pkg::DVD_W;
    localparam int NS = gpm_pkg::DIV_STEPS;

    gpm_pkg::div_st_t   st_reg   [NS];
    logic [MW-1:0]      den_reg  [NS];
    gpm_pkg::div_side_t side_reg [NS];

    gpm_pkg::div_st_t   st_in;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic gpm_pkg::div_st_t div_step(input gpm_pkg::div_st_t s,
                                                  input logic [MW-1:0] d);
        gpm_pkg::div_st_t r;
        logic [MW:0]      cur;
        logic [MW+1:0]    sub;
        cur   = {s.rem, s.dq[VW-1]};
        sub   = {1'b0, cur} - {2'b00, d};
        r.dq  = {s.dq[VW-2:0], ~sub[MW+1]};
        r.rem = sub[MW+1] ? cur[MW-1:0] : sub[MW-1:0];
        return r;
    endfunction

    assign st_in.rem = '0;
    assign st_in.dq  = dividend;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= div_step(st_in, den);
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int i = 1; i < NS; i++)
            begin
                st_reg[i]   <= div_step(st_reg[i-1], den_reg[i-1]);
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign quotient  = st_reg[NS-1].dq;
    assign remainder = st_reg[NS-1].rem;
    assign side_out  = side_reg[NS-1];

endmodule

`default_nettype wire

@@ rtl/gpm_sqrt.sv @@
`default_nettype none

module gpm_sqrt (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [gpm_pkg::DVD_W-1:0]  radicand,
    input  wire gpm_pkg::sq_side_t          side_in,
    output logic [gpm_pkg::ROOT_W-1:0]      root,
    output logic                            rem_nz,
    output gpm_pkg::sq_side_t               side_out
);

    localparam int RW = gpm_pkg::RS_W;
    localparam int OW = gpm_pkg::ROOT_W;
    localparam int AW = gpm_pkg::RAD_W;
    localparam int NS = gpm_pkg::SQRT_STEPS;

    gpm_pkg::sq_st_t   st_reg   [NS];
    gpm_pkg::sq_side_t side_reg [NS];

    gpm_pkg::sq_st_t   st_in;

    // one digit-by-digit root step on the next bit pair
    function automatic gpm_pkg::sq_st_t sq_step(input gpm_pkg::sq_st_t s);
        gpm_pkg::sq_st_t r;
        logic [RW+1:0]   cur;
        logic [RW+2:0]   sub;
        cur   = {s.rs, s.rad[AW-1 -: 2]};
        sub   = {1'b0, cur} - (RW + 3)'({s.root, 2'b01});
        r.rad = {s.rad[AW-3:0], 2'b00};
        if (!sub[RW+2])
        begin
            r.rs   = sub[RW-1:0];
            r.root = {s.root[OW-2:0], 1'b1};
        end
        else
        begin
            r.rs   = cur[RW-1:0];
            r.root = {s.root[OW-2:0], 1'b0};
        end
        return r;
    endfunction

    assign st_in.rs   = '0;
    assign st_in.root = '0;
    assign st_in.rad  = AW'(radicand);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= sq_step(st_in);
            side_reg[0] <= side_in;
            for (int i = 1; i < NS; i++)
            begin
                st_reg[i]   <= sq_step(st_reg[i-1]);
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign root     = st_reg[NS-1].root;
    assign rem_nz   = |st_reg[NS-1].rs;
    assign side_out = side_reg[NS-1];

endmodule

`default_nettype wire

@@ rtl/gpm_cordic.sv @@
`default_nettype none

module gpm_cordic (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [gpm_pkg::DIFF_W-1:0]   vx,
    input  wire logic signed [gpm_pkg::DIFF_W-1:0]   vy,
    input  wire logic signed [gpm_pkg::DIFF_W-1:0]   dx,
    input  wire logic signed [gpm_pkg::DIFF_W-1:0]   dy,
    output logic [gpm_pkg::T_FRAC_BITS-1:0]          ang_t
);

    localparam int CW = gpm_pkg::CW;
    localparam int DW = gpm_pkg::DIFF_W;
    localparam int AW = gpm_pkg::ANG_W;
    localparam int NS = gpm_pkg::CORDIC_STEPS;
    localparam int TF = gpm_pkg::T_FRAC_BITS;
    localparam int ND = gpm_pkg::ANG_DLY;

    gpm_pkg::cvec_t  cv_reg [NS+1];
    gpm_pkg::cvec_t  cd_reg [NS+1];
    logic [TF-1:0]   ang_reg;
    logic [TF-1:0]   ang_dly_reg [ND];
    logic [AW-1:0]   ang_diff;

    // left half plane turned by a half turn, then scaled up
    function automatic gpm_pkg::cvec_t cinit(input logic signed [DW-1:0] x,
                                             input logic signed [DW-1:0] y);
        gpm_pkg::cvec_t      r;
        logic signed [CW-1:0] xe, ye;
        xe  = CW'(x);
        ye  = CW'(y);
        r.a = '0;
        if (xe < 0)
        begin
            xe  = -xe;
            ye  = -ye;
            r.a = gpm_pkg::HALF_TURN;
        end
        r.x = xe <<< gpm_pkg::CORDIC_SCALE;
        r.y = ye <<< gpm_pkg::CORDIC_SCALE;
        return r;
    endfunction

    // vectoring micro-rotation, held once y has reached zero
    function automatic gpm_pkg::cvec_t cstep(input gpm_pkg::cvec_t v,
                                             input logic [4:0] sh);
        gpm_pkg::cvec_t      r;
        logic signed [CW-1:0] xs, ys;
        r  = v;
        xs = $signed(v.x) >>> sh;
        ys = $signed(v.y) >>> sh;
        if (v.y != '0)
        begin
            if (!v.y[CW-1])
            begin
                r.x = v.x + ys;
                r.y = v.y - xs;
                r.a = v.a + gpm_pkg::turn_step(sh);
            end
            else
            begin
                r.x = v.x - ys;
                r.y = v.y + xs;
                r.a = v.a - gpm_pkg::turn_step(sh);
            end
        end
        return r;
    endfunction

    assign ang_diff = cv_reg[NS].a - cd_reg[NS].a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cv_reg[0] <= cinit(vx, vy);
            cd_reg[0] <= cinit(dx, dy);
            for (int i = 0; i < NS; i++)
            begin
                cv_reg[i+1] <= cstep(cv_reg[i], 5'(i));
                cd_reg[i+1] <= cstep(cd_reg[i], 5'(i));
            end
            ang_reg        <= ang_diff[AW-1 -: TF];
            ang_dly_reg[0] <= ang_reg;
            for (int i = 1; i < ND; i++)
            begin
                ang_dly_reg[i] <= ang_dly_reg[i-1];
            end
        end
    end

    assign ang_t = ang_dly_reg[ND-1];

endmodule

`default_nettype wire

@@ verif/gradient_parameter_mapper_test.sv @@
`timescale 1ns / 1ps

module gradient_parameter_mapper_test;

    import gpm_pkg::*;

    localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
    localparam logic [1:0] SPREAD_UNKNOWN = 2'd3;
    localparam int         FLUSH_CYCLES   = 140;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005};

    class ramp_scoreboard;
        logic [T_W-1:0] pending [$];
        int             mismatches;

        function void note_pixel(logic [T_W-1:0] t);
            pending.push_back(t);
        endfunction

        function void check_ramp(logic [T_W-1:0] got);
            logic [T_W-1:0] want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected ramp transfer: got %0d", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ramp_position mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [COORD_BITS-1:0]         cfg_data = '0;
    logic                          pixel_valid = 1'b0;
    logic                          pixel_stall;
    logic signed [COORD_BITS-1:0]  pixel_x = '0;
    logic signed [COORD_BITS-1:0]  pixel_y = '0;
    logic                          ramp_valid;
    logic                          ramp_stall = 1'b0;
    logic [T_W-1:0]                ramp_position;

    logic signed [COORD_BITS-1:0]  grad_sx = '0, grad_sy = '0, grad_ex = '0, grad_ey = '0;
    logic [1:0]                    grad_kind = '0, grad_spread = '0;
    bit                            no_idle;
    ramp_scoreboard                sb;

    gradient_parameter_mapper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .ramp_valid    (ramp_valid),
        .ramp_stall    (ramp_stall),
        .ramp_position (ramp_position)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] vector_turn(longint x, longint y);
        logic [31:0] ang;
        longint      xs, ys;
        ang = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        x = x * (longint'(1) << CORDIC_SCALE);
        y = y * (longint'(1) << CORDIC_SCALE);
        for (int i = 0; i < CORDIC_STEPS && y != 0; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                ang = ang + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang = ang - ATAN_TURNS[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [T_W-1:0] fold_spread(longint q, logic [T_FRAC_BITS-1:0] f,
                                                   bit inexact);
        if (grad_spread == SPREAD_REPEAT)
            return {1'b0, f};
        if (grad_spread == SPREAD_REFLECT)
        begin
            if (q[0] == 1'b0)
                return {1'b0, f};
            if (f == 0 && !inexact)
                return ONE_T;
            return ONE_T - T_W'(f) - T_W'(inexact);
        end
        if (q < 0)
            return '0;
        if (q >= 1)
            return ONE_T;
        return {1'b0, f};
    endfunction

    function automatic logic [T_W-1:0] ramp_at(logic signed [COORD_BITS-1:0] px,
                                               logic signed [COORD_BITS-1:0] py);
        longint                 dx, dy, vx, vy, den, num, q, rs;
        logic [63:0]            r, qi, rem, root, pair, trial, f, unum, uden;
        logic [31:0]            a;
        dx = longint'(grad_ex) - longint'(grad_sx);
        dy = longint'(grad_ey) - longint'(grad_sy);
        vx = longint'(px) - longint'(grad_sx);
        vy = longint'(py) - longint'(grad_sy);
        den = dx * dx + dy * dy;
        if (den == 0)
            return '0;
        if (grad_kind == KIND_LINEAR)
        begin
            num = vx * dx + vy * dy;
            q = num / den;
            rs = num % den;
            if (rs < 0)
            begin
                rs = rs + den;
                q = q - 1;
            end
            r = rs;
            f = 0;
            for (int k = 0; k < T_FRAC_BITS; k++)
            begin
                r = r << 1;
                f = f << 1;
                if (r >= den)
                begin
                    r = r - den;
                    f[0] = 1'b1;
                end
            end
            return fold_spread(q, f[T_FRAC_BITS-1:0], r != 0);
        end
        if (grad_kind == KIND_RADIAL)
        begin
            unum = vx * vx + vy * vy;
            uden = den;
            qi = unum / uden;
            r = unum % uden;
            rem = 0;
            root = 0;
            for (int k = 0; k < 32 + T_FRAC_BITS; k++)
            begin
                if (k < 32)
                    pair = (qi >> (62 - 2 * k)) & 64'd3;
                else
                begin
                    pair = 0;
                    for (int b = 0; b < 2; b++)
                    begin
                        r = r << 1;
                        pair = pair << 1;
                        if (r >= uden)
                        begin
                            r = r - uden;
                            pair[0] = 1'b1;
                        end
                    end
                end
                rem = (rem << 2) | pair;
                trial = (root << 2) | 64'd1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    root = (root << 1) | 64'd1;
                end
                else
                    root = root << 1;
            end
            return fold_spread(longint'(root >> T_FRAC_BITS), root[T_FRAC_BITS-1:0],
                               rem != 0 || r != 0);
        end
        if (grad_kind == KIND_ANGULAR)
        begin
            a = vector_turn(vx, vy) - vector_turn(dx, dy);
            return T_W'(a >> (32 - T_FRAC_BITS));
        end
        return '0;
    endfunction

    // predictor shadow registers and scoreboard hooks
    always @(posedge clk)
    begin
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_START_X:     grad_sx <= cfg_data;
                CFG_START_Y:     grad_sy <= cfg_data;
                CFG_END_X:       grad_ex <= cfg_data;
                CFG_END_Y:       grad_ey <= cfg_data;
                CFG_SHAPE_KIND:  grad_kind <= cfg_data[1:0];
                CFG_SPREAD_MODE: grad_spread <= cfg_data[1:0];
                default:         ;
            endcase
        end
        if (rst_n && pixel_valid && !pixel_stall)
            sb.note_pixel(ramp_at(pixel_x, pixel_y));
        if (rst_n && ramp_valid && !ramp_stall)
            sb.check_ramp(ramp_position);
    end

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // the enable stays high across back-to-back writes; callers drop it
    task automatic write_reg(cfg_idx_t idx, logic [COORD_BITS-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (pixel_stall);
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] c,
                                                                int span);
        longint v;
        v = longint'(c) + longint'($urandom_range(0, 2 * span)) - span;
        if (v > longint'(COORD_MAX))
            v = COORD_MAX;
        if (v < longint'(COORD_MIN))
            v = COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return grad_sx;
            3:       return grad_ey;
            4:       return '0;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // receiver side
    initial
    begin
        int n;
        @(posedge clk iff rst_n);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                ramp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            ramp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!ramp_valid);
        end
    end

    initial
    begin
        logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
        int                           span, pick;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero drag after reset, then extremes across the full plane
        send_pixel(COORD_MAX, COORD_MIN);
        send_pixel('0, '0);
        drain();
        write_reg(CFG_START_X, COORD_MIN);
        write_reg(CFG_START_Y, COORD_MIN);
        write_reg(CFG_END_X, COORD_MAX);
        write_reg(CFG_END_Y, COORD_MAX);
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_SHAPE_KIND,
                      COORD_BITS'((k == 3) ? KIND_UNKNOWN : 2'(k)));
            write_reg(CFG_SPREAD_MODE,
                      COORD_BITS'((k == 3) ? SPREAD_UNKNOWN : 2'(SPREAD_REFLECT)));
            cfg_write_en <= 1'b0;
            @(posedge clk);
            send_pixel(COORD_MIN, COORD_MIN);
            send_pixel(COORD_MAX, COORD_MAX);
            send_pixel(COORD_MIN, COORD_MAX);
            send_pixel(COORD_MAX, COORD_MIN);
            send_pixel('0, '0);
            drain();
        end

        for (int p = 0; p < 14; p++)
        begin
            no_idle = (p % 4 == 3);
            span = (p % 3 == 0) ? 256 : (p % 3 == 1) ? 65536 : 4000000;
            sx = COORD_BITS'($urandom);
            sy = COORD_BITS'($urandom);
            if (p % 5 != 4)
            begin
                sx = sx >>> 4;
                sy = sy >>> 4;
            end
            ex = near_coord(sx, span);
            ey = near_coord(sy, span);
            if (p == 6)
            begin
                ex = sx;
                ey = sy;
            end
            if (p == 9)
            begin
                sx = COORD_MAX;
                sy = COORD_MIN;
                ex = COORD_MIN;
                ey = COORD_MAX;
            end
            write_reg(CFG_START_X, sx);
            write_reg(CFG_START_Y, sy);
            write_reg(CFG_END_X, ex);
            write_reg(CFG_END_Y, ey);
            write_reg(CFG_SHAPE_KIND,
                      COORD_BITS'((p == 13) ? KIND_UNKNOWN : 2'(p % 3)));
            write_reg(CFG_SPREAD_MODE,
                      COORD_BITS'((p == 11) ? SPREAD_UNKNOWN : 2'((p / 3) % 3)));
            cfg_write_en <= 1'b0;
            @(posedge clk);
            for (int i = 0; i < 46; i++)
            begin
                pick = $urandom_range(0, 7);
                if (pick < 5)
                    send_pixel(near_coord(sx, 3 * span), near_coord(sy, 3 * span));
                else if (pick == 5)
                    send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
                else
                    send_pixel(edge_coord(), edge_coord());
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
